FILE: hdl/slip_response_decoder_defines.svh
// assertion macros for the decoder rtl
`ifndef SLIP_RESPONSE_DECODER_DEFINES_SVH
`define SLIP_RESPONSE_DECODER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/slip_rd_pkg.sv
// types and constants for the slip response decoder
package slip_rd_pkg;

  localparam int unsigned MtuBytes = 256;
  localparam int unsigned CountW   = 9;

  localparam logic [7:0] FrameEnd  = 8'hC0;
  localparam logic [7:0] EscByte   = 8'hDB;
  localparam logic [7:0] EscEnd    = 8'hDC;
  localparam logic [7:0] EscEsc    = 8'hDD;
  localparam logic [7:0] DirResp   = 8'h01;
  localparam logic [15:0] HdrBytes = 16'd4;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DECODING = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_ERROR    = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
    logic [7:0] cmd;
  } item_t;

  typedef struct packed {
    status_e     decode_status;
    logic        exchange_ok;
    logic        data_valid;
    logic [7:0]  data_index;
    logic [7:0]  data_byte;
    logic [7:0]  resp_command;
    logic [15:0] resp_size;
    logic [31:0] resp_value;
    logic [7:0]  resp_status;
    logic [7:0]  resp_error;
  } result_t;

endpackage

FILE: hdl/slip_rd_front.sv
// front end: takes input words, classifies the operation, two-entry queue
module slip_rd_front import slip_rd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] expected_command_i,
  output logic       item_valid_o,
  output item_t      item_o,
  input  logic       item_take_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  item_t      item_new;

  always_comb begin
    unique case (operation_i)
      2'd0:    item_new.op = OP_BYTE;
      2'd1:    item_new.op = OP_BEGIN;
      2'd2:    item_new.op = OP_TIMEOUT;
      default: item_new.op = OP_NONE;
    endcase
    item_new.rx_byte = rx_byte_i;
    item_new.cmd     = expected_command_i;
  end

  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hdl/slip_rd_back.sv
// back end: frame parser state machine and result register
module slip_rd_back import slip_rd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_take_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_pop_i
);

`include "slip_response_decoder_defines.svh"

  localparam logic [2:0] PhStart = 3'd0;
  localparam logic [2:0] PhDir   = 3'd1;
  localparam logic [2:0] PhCmd   = 3'd2;
  localparam logic [2:0] PhSize  = 3'd3;
  localparam logic [2:0] PhValue = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;
  localparam logic [2:0] PhEnd   = 3'd6;
  localparam logic [2:0] PhError = 3'd7;

  logic [2:0]        phase_q, phase_d;
  logic [7:0]        want_q, want_d;
  logic [7:0]        size_lo_q, size_lo_d;
  logic [1:0]        hdr_cnt_q, hdr_cnt_d;
  logic [31:0]       value_q, value_d;
  logic [CountW-1:0] pay_cnt_q, pay_cnt_d;
  logic              esc_q, esc_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [15:0]       size_q, size_d;
  logic [7:0]        status_q, status_d;
  logic [7:0]        error_q, error_d;

  logic    out_valid_q;
  result_t res_q, res_d;
  status_e st;
  logic    dv;
  logic [7:0]  di, db, c;
  logic [15:0] plen, cnt16, new_size;

  assign item_take_o = item_valid_i && (!out_valid_q || res_pop_i);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign c        = item_i.rx_byte;
  assign plen     = size_q - HdrBytes;
  assign cnt16    = {{(16 - CountW){1'b0}}, pay_cnt_q};
  assign new_size = {c, size_lo_q};

  always_comb begin
    phase_d   = phase_q;
    want_d    = want_q;
    size_lo_d = size_lo_q;
    hdr_cnt_d = hdr_cnt_q;
    value_d   = value_q;
    pay_cnt_d = pay_cnt_q;
    esc_d     = esc_q;
    cmd_d     = cmd_q;
    size_d    = size_q;
    status_d  = status_q;
    error_d   = error_q;
    st        = ST_DECODING;
    dv        = 1'b0;
    di        = 8'd0;
    db        = 8'd0;
    unique case (item_i.op)
      OP_BYTE: begin
        unique case (phase_q)
          PhStart: begin
            status_d = 8'd1;
            if (c == FrameEnd) phase_d = PhDir;
          end
          PhDir: begin
            if (c == DirResp) begin
              phase_d = PhCmd;
            end else begin
              phase_d = PhError;
              st      = ST_ERROR;
            end
          end
          PhCmd: begin
            cmd_d     = c;
            hdr_cnt_d = 2'd0;
            if (c == want_q) begin
              phase_d = PhSize;
            end else begin
              phase_d = PhError;
              st      = ST_ERROR;
            end
          end
          PhSize: begin
            if (hdr_cnt_q == 2'd0) begin
              size_lo_d = c;
              hdr_cnt_d = 2'd1;
            end else begin
              size_d    = new_size;
              hdr_cnt_d = 2'd0;
              if (new_size >= HdrBytes && {1'b0, new_size} < 17'(MtuBytes)) begin
                phase_d = PhValue;
              end else begin
                phase_d = PhError;
                st      = ST_ERROR;
              end
            end
          end
          PhValue: begin
            value_d = {c, value_q[31:8]};
            if (hdr_cnt_q == 2'd3) begin
              hdr_cnt_d = 2'd0;
              pay_cnt_d = '0;
              esc_d     = 1'b0;
              phase_d   = PhData;
            end else begin
              hdr_cnt_d = hdr_cnt_q + 2'd1;
            end
          end
          PhData: begin
            if (cnt16 < plen) begin
              if (esc_q) begin
                esc_d = 1'b0;
                if (c == EscEnd || c == EscEsc) begin
                  dv        = 1'b1;
                  di        = pay_cnt_q[7:0];
                  db        = (c == EscEnd) ? FrameEnd : EscByte;
                  pay_cnt_d = pay_cnt_q + 1'b1;
                end else begin
                  phase_d = PhError;
                  st      = ST_ERROR;
                end
              end else if (c == EscByte) begin
                esc_d = 1'b1;
              end else begin
                dv        = 1'b1;
                di        = pay_cnt_q[7:0];
                db        = c;
                pay_cnt_d = pay_cnt_q + 1'b1;
              end
            end else begin
              // trailer: status, error, two ignored bytes
              if (cnt16 == plen) status_d = c;
              if (cnt16 == plen + 16'd1) error_d = c;
              if (cnt16 == plen + 16'd3) phase_d = PhEnd;
              pay_cnt_d = pay_cnt_q + 1'b1;
            end
          end
          PhEnd: begin
            if (c == FrameEnd) begin
              phase_d = PhStart;
              st      = ST_COMPLETE;
            end else begin
              phase_d = PhError;
              st      = ST_ERROR;
            end
          end
          default: begin
            phase_d = PhError;
            st      = ST_ERROR;
          end
        endcase
      end
      OP_BEGIN: begin
        want_d    = item_i.cmd;
        phase_d   = PhStart;
        status_d  = 8'd1;
        cmd_d     = 8'd0;
        size_d    = 16'd0;
        value_d   = 32'd0;
        hdr_cnt_d = 2'd0;
        pay_cnt_d = '0;
        esc_d     = 1'b0;
      end
      OP_TIMEOUT: begin
        phase_d = PhError;
        st      = ST_ERROR;
      end
      default: begin
        st = (phase_q == PhError) ? ST_ERROR : ST_DECODING;
      end
    endcase

    res_d.decode_status = st;
    res_d.exchange_ok   = (st == ST_COMPLETE) && (status_d == 8'd0);
    res_d.data_valid    = dv;
    res_d.data_index    = di;
    res_d.data_byte     = db;
    res_d.resp_command  = cmd_d;
    res_d.resp_size     = size_d;
    res_d.resp_value    = value_d;
    res_d.resp_status   = status_d;
    res_d.resp_error    = error_d;
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStart;
      want_q      <= 8'd0;
      size_lo_q   <= 8'd0;
      hdr_cnt_q   <= 2'd0;
      value_q     <= 32'd0;
      pay_cnt_q   <= '0;
      esc_q       <= 1'b0;
      cmd_q       <= 8'd0;
      size_q      <= 16'd0;
      status_q    <= 8'd1;
      error_q     <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_take_o) begin
        phase_q   <= phase_d;
        want_q    <= want_d;
        size_lo_q <= size_lo_d;
        hdr_cnt_q <= hdr_cnt_d;
        value_q   <= value_d;
        pay_cnt_q <= pay_cnt_d;
        esc_q     <= esc_d;
        cmd_q     <= cmd_d;
        size_q    <= size_d;
        status_q  <= status_d;
        error_q   <= error_d;
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SRD_ASSERT(a_dv_while_decoding, !out_valid_q || !res_q.data_valid || res_q.decode_status == ST_DECODING, "payload word flagged with a final status")
  `SRD_ASSERT(a_ok_needs_complete, !out_valid_q || !res_q.exchange_ok || res_q.decode_status == ST_COMPLETE, "exchange ok without a complete frame")
  `SRD_ASSERT_NEXT(a_error_sticky, item_take_o && item_i.op == OP_BYTE && phase_q == PhError, res_q.decode_status == ST_ERROR && phase_q == PhError, "error phase left on a byte")
  `SRD_ASSERT_NEXT(a_timeout_error, item_take_o && item_i.op == OP_TIMEOUT, out_valid_q && phase_q == PhError, "timeout did not fail the exchange")

endmodule

FILE: hdl/slip_response_decoder.sv
// top level of the slip response decoder
// usage:
//   input queue: drive operation_i, rx_byte_i and expected_command_i and raise
//   push; the word is taken at a clock edge with push high and full low.
//   operation 0 feeds one received byte, 1 starts a new exchange and latches
//   the expected command, 2 reports a receive timeout, 3 changes nothing.
//   result queue: while empty is low the oldest result sits on the result
//   ports; it is taken at an edge with pop high. every input word yields
//   exactly one result word.
// path: a taken word waits in the front queue, is parsed into the result
//   register and can be popped from there.
// throughput: one word per cycle while pop stays high, the back end parser
//   updating on each taken word; front and back are split by a two-entry queue.
// stall: with pop held low the result register keeps its word, the parser
//   stops and the front queue fills; full rises once two words wait there.
//   nothing is dropped.
// reset: rst_ni low clears both queues and puts the parser in the wait for
//   start phase with held status one and all other captured fields zero.
module slip_response_decoder import slip_rd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  expected_command_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  decode_status_o,
  output logic        exchange_ok_o,
  output logic        data_valid_o,
  output logic [7:0]  data_index_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  resp_command_o,
  output logic [15:0] resp_size_o,
  output logic [31:0] resp_value_o,
  output logic [7:0]  resp_status_o,
  output logic [7:0]  resp_error_o
);

  // words waiting between front and back
  logic    item_valid;
  item_t   item;
  logic    item_take;
  // parsed result word
  logic    res_valid;
  result_t res;

  slip_rd_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .operation_i        (operation_i),
    .rx_byte_i          (rx_byte_i),
    .expected_command_i (expected_command_i),
    .item_valid_o       (item_valid),
    .item_o             (item),
    .item_take_i        (item_take)
  );

  slip_rd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  // result ports straight from the result register
  assign empty           = !res_valid;
  assign decode_status_o = res.decode_status;
  assign exchange_ok_o   = res.exchange_ok;
  assign data_valid_o    = res.data_valid;
  assign data_index_o    = res.data_index;
  assign data_byte_o     = res.data_byte;
  assign resp_command_o  = res.resp_command;
  assign resp_size_o     = res.resp_size;
  assign resp_value_o    = res.resp_value;
  assign resp_status_o   = res.resp_status;
  assign resp_error_o    = res.resp_error;

endmodule

FILE: sim/slip_rd_scoreboard_pkg.sv
// scoreboard with the frame parser prediction for the slip response decoder bench
package slip_rd_scoreboard_pkg;
  import slip_rd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT_START,
    PH_DIRECTION,
    PH_COMMAND,
    PH_SIZE,
    PH_VALUE,
    PH_PAYLOAD,
    PH_CLOSE,
    PH_ERROR
  } parse_phase_e;

  class slip_response_scoreboard;
    parse_phase_e phase;
    logic [7:0]   want_cmd;
    logic [7:0]   size_lo;
    logic [1:0]   hdr_cnt;
    logic [31:0]  value_sh;
    logic [8:0]   pay_cnt;
    logic         esc_pend;
    logic [7:0]   held_cmd;
    logic [15:0]  held_size;
    logic [7:0]   held_status;
    logic [7:0]   held_error;
    result_t      expected_words[$];
    int unsigned  errors;

    function new();
      phase       = PH_WAIT_START;
      want_cmd    = '0;
      size_lo     = '0;
      hdr_cnt     = '0;
      value_sh    = '0;
      pay_cnt     = '0;
      esc_pend    = 1'b0;
      held_cmd    = '0;
      held_size   = '0;
      held_status = 8'd1;
      held_error  = '0;
      errors      = 0;
    endfunction

    // advance the parser by one word and return the result it must give
    function result_t parse_word(item_t w);
      result_t     r;
      status_e     st;
      logic [7:0]  b;
      logic [15:0] plen;
      r  = '0;
      st = ST_DECODING;
      b  = w.rx_byte;
      case (w.op)
        OP_BYTE: begin
          case (phase)
            PH_WAIT_START: begin
              held_status = 8'd1;
              if (b == FrameEnd) phase = PH_DIRECTION;
            end
            PH_DIRECTION: begin
              if (b == DirResp) phase = PH_COMMAND;
              else begin
                phase = PH_ERROR;
                st    = ST_ERROR;
              end
            end
            PH_COMMAND: begin
              held_cmd = b;
              hdr_cnt  = '0;
              if (b == want_cmd) phase = PH_SIZE;
              else begin
                phase = PH_ERROR;
                st    = ST_ERROR;
              end
            end
            PH_SIZE: begin
              if (hdr_cnt == 2'd0) begin
                size_lo = b;
                hdr_cnt = 2'd1;
              end else begin
                held_size = {b, size_lo};
                hdr_cnt   = '0;
                if (held_size >= HdrBytes && held_size < MtuBytes) phase = PH_VALUE;
                else begin
                  phase = PH_ERROR;
                  st    = ST_ERROR;
                end
              end
            end
            PH_VALUE: begin
              value_sh = {b, value_sh[31:8]};
              if (hdr_cnt == 2'd3) begin
                hdr_cnt  = '0;
                pay_cnt  = '0;
                esc_pend = 1'b0;
                phase    = PH_PAYLOAD;
              end else begin
                hdr_cnt = hdr_cnt + 2'd1;
              end
            end
            PH_PAYLOAD: begin
              plen = held_size - HdrBytes;
              if (16'(pay_cnt) < plen) begin
                if (esc_pend) begin
                  esc_pend = 1'b0;
                  if (b == EscEnd || b == EscEsc) begin
                    r.data_valid = 1'b1;
                    r.data_index = pay_cnt[7:0];
                    r.data_byte  = (b == EscEnd) ? FrameEnd : EscByte;
                    pay_cnt      = pay_cnt + 9'd1;
                  end else begin
                    phase = PH_ERROR;
                    st    = ST_ERROR;
                  end
                end else if (b == EscByte) begin
                  esc_pend = 1'b1;
                end else begin
                  r.data_valid = 1'b1;
                  r.data_index = pay_cnt[7:0];
                  r.data_byte  = b;
                  pay_cnt      = pay_cnt + 9'd1;
                end
              end else begin
                // trailer bytes are taken raw
                if (16'(pay_cnt) == plen) held_status = b;
                if (16'(pay_cnt) == plen + 16'd1) held_error = b;
                if (16'(pay_cnt) == plen + 16'd3) phase = PH_CLOSE;
                pay_cnt = pay_cnt + 9'd1;
              end
            end
            PH_CLOSE: begin
              if (b == FrameEnd) begin
                phase = PH_WAIT_START;
                st    = ST_COMPLETE;
              end else begin
                phase = PH_ERROR;
                st    = ST_ERROR;
              end
            end
            default: begin
              phase = PH_ERROR;
              st    = ST_ERROR;
            end
          endcase
        end
        OP_BEGIN: begin
          want_cmd    = w.cmd;
          phase       = PH_WAIT_START;
          held_status = 8'd1;
          held_cmd    = '0;
          held_size   = '0;
          value_sh    = '0;
          hdr_cnt     = '0;
          pay_cnt     = '0;
          esc_pend    = 1'b0;
        end
        OP_TIMEOUT: begin
          phase = PH_ERROR;
          st    = ST_ERROR;
        end
        default: st = (phase == PH_ERROR) ? ST_ERROR : ST_DECODING;
      endcase
      r.decode_status = st;
      r.exchange_ok   = (st == ST_COMPLETE) && (held_status == 8'd0);
      r.resp_command  = held_cmd;
      r.resp_size     = held_size;
      r.resp_value    = value_sh;
      r.resp_status   = held_status;
      r.resp_error    = held_error;
      return r;
    endfunction

    function void note_word(item_t w);
      expected_words.push_back(parse_word(w));
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t exp_w;
      if (expected_words.size() == 0) begin
        $error("result word popped with nothing expected");
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      compare_field("decode_status", exp_w.decode_status, got.decode_status);
      compare_field("exchange_ok", exp_w.exchange_ok, got.exchange_ok);
      compare_field("data_valid", exp_w.data_valid, got.data_valid);
      compare_field("data_index", exp_w.data_index, got.data_index);
      compare_field("data_byte", exp_w.data_byte, got.data_byte);
      compare_field("resp_command", exp_w.resp_command, got.resp_command);
      compare_field("resp_size", exp_w.resp_size, got.resp_size);
      compare_field("resp_value", exp_w.resp_value, got.resp_value);
      compare_field("resp_status", exp_w.resp_status, got.resp_status);
      compare_field("resp_error", exp_w.resp_error, got.resp_error);
    endfunction
  endclass

endpackage

FILE: sim/tb.sv
// testbench top for the slip response decoder
module tb;
  import slip_rd_pkg::*;
  import slip_rd_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted word before the run is declared hung
  localparam int unsigned QuietLimit = 1000;
  // rough count of live words for the random part
  localparam int unsigned RandomWords = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  operation_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  expected_command_i = '0;
  logic        full;
  logic        empty;
  logic [1:0]  decode_status_o;
  logic        exchange_ok_o;
  logic        data_valid_o;
  logic [7:0]  data_index_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  resp_command_o;
  logic [15:0] resp_size_o;
  logic [31:0] resp_value_o;
  logic [7:0]  resp_status_o;
  logic [7:0]  resp_error_o;

  slip_response_scoreboard sb;

  // stimulus words, built up front and then fed in bursts
  item_t       word_q[$];
  int unsigned live_words = 0;
  logic [7:0]  gen_want = '0;
  logic        gen_broken = 1'b1;

  // receiver stall pattern state
  int unsigned rx_mode = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_tick = 0;
  int unsigned quiet_cycles = 0;

  slip_response_decoder u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .operation_i       (operation_i),
    .rx_byte_i         (rx_byte_i),
    .expected_command_i(expected_command_i),
    .empty             (empty),
    .pop               (pop),
    .decode_status_o   (decode_status_o),
    .exchange_ok_o     (exchange_ok_o),
    .data_valid_o      (data_valid_o),
    .data_index_o      (data_index_o),
    .data_byte_o       (data_byte_o),
    .resp_command_o    (resp_command_o),
    .resp_size_o       (resp_size_o),
    .resp_value_o      (resp_value_o),
    .resp_status_o     (resp_status_o),
    .resp_error_o      (resp_error_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void queue_word(op_e op, logic [7:0] rx, logic [7:0] cmd);
    item_t w;
    w.op      = op;
    w.rx_byte = rx;
    w.cmd     = cmd;
    word_q.push_back(w);
    if (op != OP_NONE) live_words++;
  endfunction

  // received byte, now and then preceded by an idle op or a line timeout
  function automatic void queue_rx(logic [7:0] b);
    int unsigned r;
    r = $urandom_range(0, 199);
    if (r < 5) begin
      queue_word(OP_NONE, 8'($urandom), 8'($urandom));
    end else if (r == 5) begin
      queue_word(OP_TIMEOUT, 8'($urandom), 8'($urandom));
      gen_broken = 1'b1;
    end
    queue_word(OP_BYTE, b, 8'($urandom));
  endfunction

  // random byte leaning toward the framing codes and the extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] marks [7] = '{FrameEnd, EscByte, EscEnd, EscEsc, 8'h00, 8'hFF, DirResp};
    if ($urandom_range(0, 3) == 0) return marks[$urandom_range(0, 6)];
    return 8'($urandom);
  endfunction

  // short hand-made sequence: one good frame with an escaped payload byte,
  // then a bad direction byte, an idle op in the error phase, a timeout
  // and a byte while the error sticks
  function automatic void build_directed();
    logic [7:0] frame [19] = '{
      8'h00, FrameEnd, DirResp, 8'hFF, 8'h05, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, EscByte, EscEnd,
      8'h00, 8'hFF, 8'hFF, 8'h00, FrameEnd, FrameEnd, 8'h02
    };
    queue_word(OP_NONE, 8'hFF, 8'hFF);
    queue_word(OP_BEGIN, 8'h00, 8'hFF);
    foreach (frame[i]) queue_word(OP_BYTE, frame[i], 8'h00);
    queue_word(OP_NONE, 8'h00, 8'h00);
    queue_word(OP_TIMEOUT, 8'hFF, 8'h00);
    queue_word(OP_BYTE, 8'h00, 8'hFF);
    gen_want   = 8'hFF;
    gen_broken = 1'b1;
  endfunction

  // one exchange: mostly a well formed frame, sometimes with a single flaw
  function automatic void build_exchange();
    int unsigned flaw, r, n, cut, i;
    logic [15:0] size;
    logic [7:0]  raw, b;
    // 0..6 clean, 7 direction, 8 command, 9 size, 10 escape, 11 close
    flaw = $urandom_range(0, 11);
    if (gen_broken || $urandom_range(0, 6) == 0) begin
      gen_want = 8'($urandom);
      queue_word(OP_BEGIN, 8'($urandom), gen_want);
      gen_broken = 1'b0;
    end
    // line noise ahead of the frame start
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    for (i = 0; i < n; i++) begin
      b = pick_byte();
      queue_rx((b == FrameEnd) ? 8'h00 : b);
    end
    queue_rx(FrameEnd);
    b = 8'($urandom);
    if (b == DirResp) b = 8'h02;
    queue_rx((flaw == 7) ? b : DirResp);
    queue_rx((flaw == 8) ? (gen_want ^ 8'($urandom_range(1, 255))) : gen_want);
    r = $urandom_range(0, 99);
    if (flaw == 9) begin
      if (r < 40) size = 16'($urandom_range(0, 3));
      else if (r < 60) size = 16'(MtuBytes);
      else size = 16'($urandom_range(MtuBytes, 65535));
    end else if (r < 3) begin
      size = 16'(MtuBytes - 1);
    end else if (r < 10) begin
      size = 16'($urandom_range(25, 128));
    end else begin
      size = 16'($urandom_range((flaw == 10) ? 5 : 4, 20));
    end
    queue_rx(size[7:0]);
    queue_rx(size[15:8]);
    for (i = 0; i < 4; i++) queue_rx(pick_byte());
    if (flaw >= 7 && flaw <= 9) begin
      gen_broken = 1'b1;
      queue_rx(pick_byte());
      return;
    end
    n   = size - 4;
    cut = (flaw == 10) ? $urandom_range(0, n - 1) : n;
    for (i = 0; i < n; i++) begin
      if (i == cut) begin
        // escape code followed by anything but the two legal codes
        b = 8'($urandom);
        if (b == EscEnd || b == EscEsc) b = EscByte;
        queue_rx(EscByte);
        queue_rx(b);
        queue_rx(pick_byte());
        gen_broken = 1'b1;
        return;
      end
      r   = $urandom_range(0, 99);
      raw = (r < 12) ? FrameEnd : (r < 24) ? EscByte : 8'($urandom);
      if (raw == FrameEnd) begin
        queue_rx(EscByte);
        queue_rx(EscEnd);
      end else if (raw == EscByte) begin
        queue_rx(EscByte);
        queue_rx(EscEsc);
      end else begin
        queue_rx(raw);
      end
    end
    // status, error and two ignored bytes
    queue_rx($urandom_range(0, 1) ? 8'h00 : pick_byte());
    for (i = 0; i < 3; i++) queue_rx(pick_byte());
    if (flaw == 11) begin
      gen_broken = 1'b1;
      r = $urandom_range(0, 2);
      if (r == 0) begin
        queue_word(OP_TIMEOUT, 8'($urandom), 8'($urandom));
      end else if (r == 1) begin
        b = pick_byte();
        queue_rx((b == FrameEnd) ? 8'h00 : b);
      end
      // otherwise the frame is left open and the next begin cuts it off
    end else begin
      queue_rx(FrameEnd);
    end
  endfunction

  // offer one word and hold it until the queue takes it
  task automatic push_word(input item_t w);
    operation_i        <= w.op;
    rx_byte_i          <= w.rx_byte;
    expected_command_i <= w.cmd;
    push               <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_word(w);
  endtask

  task automatic idle_cycles(input int unsigned n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // sender: bursts of random length, random gaps, some back to back stretches
  initial begin
    int unsigned burst;
    sb = new();
    build_directed();
    while (live_words < RandomWords) build_exchange();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (word_q.size() != 0) begin
      burst = $urandom_range(1, 16);
      while (burst != 0 && word_q.size() != 0) begin
        push_word(word_q.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
    push <= 1'b0;
    // drain, then give the pipeline time to show any stray word
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver: check the word at the head, then choose pop for the next edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        sb.check_word(result_t'({decode_status_o, exchange_ok_o, data_valid_o,
                                 data_index_o, data_byte_o, resp_command_o,
                                 resp_size_o, resp_value_o, resp_status_o,
                                 resp_error_o}));
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        // sparse pops, paced by rx_tick
        2: pop <= (rx_tick % 4 == 0);
        default: begin
          // full rate with the odd long stall
          if (rx_stall_left != 0) begin
            rx_stall_left--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            rx_stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : 0;
          end
        end
      endcase
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule
